>>> design/ocr_pkg.sv
package ocr_pkg;

  // register indexes on the configuration port
  typedef enum logic {
    REG_XI_TWO_D  = 1'b0,
    REG_ETA_TWO_D = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic xi_two_d;
    logic eta_two_d;
  } cfg_t;

  localparam int unsigned APB_ADDR_BITS = 3;
  localparam int unsigned APB_DATA_BITS = 32;

endpackage

>>> design/ocr_cfg_regs.sv
module ocr_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel_i,
  input  logic                                penable_i,
  input  logic                                pwrite_i,
  input  logic [ocr_pkg::APB_ADDR_BITS-1:0]   paddr_i,
  input  logic [ocr_pkg::APB_DATA_BITS-1:0]   pwdata_i,
  output logic [ocr_pkg::APB_DATA_BITS-1:0]   prdata_o,
  output logic                                pready_o,
  output ocr_pkg::cfg_t                       cfg_o
);

  ocr_pkg::cfg_t    cfg_q, cfg_d;
  ocr_pkg::reg_idx_e idx;
  logic             wr_en;

  assign idx      = ocr_pkg::reg_idx_e'(paddr_i[2]);
  assign wr_en    = psel_i && penable_i && pwrite_i;
  assign pready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        ocr_pkg::REG_XI_TWO_D:  cfg_d.xi_two_d  = pwdata_i[0];
        ocr_pkg::REG_ETA_TWO_D: cfg_d.eta_two_d = pwdata_i[0];
        default:                cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    prdata_o = '0;
    case (idx)
      ocr_pkg::REG_XI_TWO_D:  prdata_o[0] = cfg_q.xi_two_d;
      ocr_pkg::REG_ETA_TWO_D: prdata_o[0] = cfg_q.eta_two_d;
      default:                prdata_o    = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> design/ocr_subst.sv
module ocr_subst #(
  parameter int unsigned COORD_BITS = 26,
  parameter int unsigned BLOCK_BITS = 10
) (
  input  logic                  clk_i,
  input  logic [COORD_BITS-1:0] xi_base_i,
  input  logic [COORD_BITS-1:0] xi_jnext_i,
  input  logic [COORD_BITS-1:0] xi_knext_i,
  input  logic [COORD_BITS-1:0] xi_diag_i,
  input  logic [COORD_BITS-1:0] eta_base_i,
  input  logic [COORD_BITS-1:0] eta_jnext_i,
  input  logic [COORD_BITS-1:0] eta_knext_i,
  input  logic [COORD_BITS-1:0] eta_diag_i,
  input  logic [BLOCK_BITS-1:0] blk_base_i,
  input  logic [BLOCK_BITS-1:0] blk_jnext_i,
  input  logic [BLOCK_BITS-1:0] blk_knext_i,
  input  logic [BLOCK_BITS-1:0] blk_diag_i,
  output logic [COORD_BITS-1:0] xi_o  [4],
  output logic [COORD_BITS-1:0] eta_o [4],
  output logic [BLOCK_BITS-1:0] blk_o
);

  logic [COORD_BITS-1:0] xi_q [4], xi_d [4];
  logic [COORD_BITS-1:0] eta_q [4], eta_d [4];
  logic [BLOCK_BITS-1:0] blk_q;
  logic                  j_ok, k_ok, d_ok;

  assign j_ok = (blk_jnext_i == blk_base_i);
  assign k_ok = (blk_knext_i == blk_base_i);
  assign d_ok = (blk_diag_i  == blk_base_i);

  // a corner from another donor block falls back to the lower corner
  always_comb begin
    xi_d[0]  = xi_base_i;
    xi_d[1]  = j_ok ? xi_jnext_i  : xi_base_i;
    xi_d[2]  = k_ok ? xi_knext_i  : xi_base_i;
    xi_d[3]  = d_ok ? xi_diag_i   : xi_base_i;
    eta_d[0] = eta_base_i;
    eta_d[1] = j_ok ? eta_jnext_i : eta_base_i;
    eta_d[2] = k_ok ? eta_knext_i : eta_base_i;
    eta_d[3] = d_ok ? eta_diag_i  : eta_base_i;
  end

  always_ff @(posedge clk_i) begin
    xi_q  <= xi_d;
    eta_q <= eta_d;
    blk_q <= blk_base_i;
  end

  assign xi_o  = xi_q;
  assign eta_o = eta_q;
  assign blk_o = blk_q;

endmodule

>>> design/ocr_coarse.sv
module ocr_coarse #(
  parameter int unsigned INT_BITS  = 10,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                           clk_i,
  input  logic [INT_BITS+FRAC_BITS-1:0]  val_i [4],
  input  logic                           flat_i,
  output logic [INT_BITS+FRAC_BITS-1:0]  coarse_o
);

  localparam int unsigned W = INT_BITS + FRAC_BITS;

  logic [W:0]           sab_q, scd_q;
  logic [W+1:0]         total;
  logic [W-1:0]         avg_q;
  logic [INT_BITS-1:0]  whole;
  logic [FRAC_BITS-1:0] frac;
  logic [INT_BITS:0]    whole_inc;
  logic [INT_BITS-1:0]  half_idx;
  logic [FRAC_BITS-1:0] part;
  logic [W-1:0]         coarse_d, coarse_q;

  assign total = {1'b0, sab_q} + {1'b0, scd_q};

  assign whole     = avg_q[W-1:FRAC_BITS];
  assign frac      = avg_q[FRAC_BITS-1:0];
  assign whole_inc = {1'b0, whole} + {{INT_BITS{1'b0}}, 1'b1};
  assign half_idx  = whole_inc[INT_BITS:1];

  // even index adds one before halving, odd index halves the fraction; in flat mode the fraction passes unchanged
  always_comb begin
    if (flat_i) begin
      part = frac;
    end else begin
      part = {~whole[0], frac[FRAC_BITS-1:1]};
    end
  end

  assign coarse_d = {half_idx, part};

  always_ff @(posedge clk_i) begin
    sab_q    <= {1'b0, val_i[0]} + {1'b0, val_i[1]};
    scd_q    <= {1'b0, val_i[2]} + {1'b0, val_i[3]};
    avg_q    <= total[W+1:2];
    coarse_q <= coarse_d;
  end

  assign coarse_o = coarse_q;

endmodule

>>> design/overset_coeff_restrict_top.sv
// Restricts one overset interpolation coefficient per transaction: a start
// pulse with busy low loads the four corners, and the coarse xi, eta and
// block number appear on the result ports once they pass the register
// stages, marked by valid_o for one cycle. The four register stages (corner
// substitution, pair sums, average, coarse mapping) let a new transaction
// enter every cycle, so busy never rises. Results leave at that fixed
// latency and must be taken when valid_o is high. The user must change the
// two-d flags only while no transaction is in flight; nothing enforces it.
module overset_coeff_restrict_top #(
  parameter int unsigned INT_BITS   = 10,
  parameter int unsigned FRAC_BITS  = 16,
  parameter int unsigned BLOCK_BITS = 10
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ocr_pkg::APB_ADDR_BITS-1:0]   paddr,
  input  logic [ocr_pkg::APB_DATA_BITS-1:0]   pwdata,
  output logic [ocr_pkg::APB_DATA_BITS-1:0]   prdata,
  output logic                                pready,
  input  logic                                start,
  output logic                                busy,
  input  logic [INT_BITS+FRAC_BITS-1:0]       xi_base_i,
  input  logic [INT_BITS+FRAC_BITS-1:0]       xi_jnext_i,
  input  logic [INT_BITS+FRAC_BITS-1:0]       xi_knext_i,
  input  logic [INT_BITS+FRAC_BITS-1:0]       xi_diag_i,
  input  logic [INT_BITS+FRAC_BITS-1:0]       eta_base_i,
  input  logic [INT_BITS+FRAC_BITS-1:0]       eta_jnext_i,
  input  logic [INT_BITS+FRAC_BITS-1:0]       eta_knext_i,
  input  logic [INT_BITS+FRAC_BITS-1:0]       eta_diag_i,
  input  logic [BLOCK_BITS-1:0]               blk_base_i,
  input  logic [BLOCK_BITS-1:0]               blk_jnext_i,
  input  logic [BLOCK_BITS-1:0]               blk_knext_i,
  input  logic [BLOCK_BITS-1:0]               blk_diag_i,
  output logic                                valid_o,
  output logic [INT_BITS+FRAC_BITS-1:0]       xi_coarse_o,
  output logic [INT_BITS+FRAC_BITS-1:0]       eta_coarse_o,
  output logic [BLOCK_BITS-1:0]               blk_coarse_o
);

  localparam int unsigned W      = INT_BITS + FRAC_BITS;
  localparam int unsigned STAGES = 4;

  ocr_pkg::cfg_t       cfg;
  logic [W-1:0]        xi_s [4];
  logic [W-1:0]        eta_s [4];
  logic [BLOCK_BITS-1:0] blk_s;
  logic [BLOCK_BITS-1:0] blk_q [STAGES-1];
  logic [STAGES-1:0]   vld_q, vld_d;
  logic                accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  ocr_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .pready_o  (pready),
    .cfg_o     (cfg)
  );

  ocr_subst #(
    .COORD_BITS (W),
    .BLOCK_BITS (BLOCK_BITS)
  ) u_subst (
    .clk_i       (clk_i),
    .xi_base_i   (xi_base_i),
    .xi_jnext_i  (xi_jnext_i),
    .xi_knext_i  (xi_knext_i),
    .xi_diag_i   (xi_diag_i),
    .eta_base_i  (eta_base_i),
    .eta_jnext_i (eta_jnext_i),
    .eta_knext_i (eta_knext_i),
    .eta_diag_i  (eta_diag_i),
    .blk_base_i  (blk_base_i),
    .blk_jnext_i (blk_jnext_i),
    .blk_knext_i (blk_knext_i),
    .blk_diag_i  (blk_diag_i),
    .xi_o        (xi_s),
    .eta_o       (eta_s),
    .blk_o       (blk_s)
  );

  ocr_coarse #(
    .INT_BITS  (INT_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_xi (
    .clk_i    (clk_i),
    .val_i    (xi_s),
    .flat_i   (cfg.xi_two_d),
    .coarse_o (xi_coarse_o)
  );

  ocr_coarse #(
    .INT_BITS  (INT_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_eta (
    .clk_i    (clk_i),
    .val_i    (eta_s),
    .flat_i   (cfg.eta_two_d),
    .coarse_o (eta_coarse_o)
  );

  // block number rides alongside the three coordinate stages
  always_ff @(posedge clk_i) begin
    blk_q[0] <= blk_s;
    for (int i = 1; i < STAGES - 1; i++) begin
      blk_q[i] <= blk_q[i-1];
    end
  end

  assign vld_d = {vld_q[STAGES-2:0], accept};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign valid_o      = vld_q[STAGES-1];
  assign blk_coarse_o = blk_q[STAGES-2];

  a_valid_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start, STAGES))
    else $error("result strobe without a matching transaction");

  a_blk_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (blk_coarse_o == $past(blk_base_i, STAGES)))
    else $error("block number out of step with coordinates");

  a_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(vld_q[0]) |=> vld_q[1])
    else $error("pipeline stage lost a transaction");

endmodule

>>> sim/overset_coeff_restrict_top_test.sv
`timescale 1ns / 1ps
module overset_coeff_restrict_top_test;

  localparam int unsigned INT_BITS   = 10;
  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned BLOCK_BITS = 10;
  localparam int unsigned COORD_BITS = INT_BITS + FRAC_BITS;
  localparam int unsigned LATENCY    = 4;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [BLOCK_BITS-1:0] blk_t;

  // corner order: 0 lower, 1 j neighbor, 2 k neighbor, 3 diagonal
  typedef struct packed {
    coord_t [3:0] xi;
    coord_t [3:0] eta;
    blk_t   [3:0] blk;
  } corners_t;

  typedef struct packed {
    coord_t xi;
    coord_t eta;
    blk_t   blk;
  } coarse_t;

  localparam coord_t COORD_MAX = '1;
  localparam blk_t   BLK_MAX   = '1;

  logic                              clk_i = 1'b0;
  logic                              rst_ni;
  logic                              psel;
  logic                              penable;
  logic                              pwrite;
  logic [ocr_pkg::APB_ADDR_BITS-1:0] paddr;
  logic [ocr_pkg::APB_DATA_BITS-1:0] pwdata;
  logic [ocr_pkg::APB_DATA_BITS-1:0] prdata;
  logic                              pready;
  logic                              start = 1'b0;
  logic                              busy;
  logic                              valid_o;
  coord_t                            xi_coarse_o;
  coord_t                            eta_coarse_o;
  blk_t                              blk_coarse_o;

  corners_t      port_item = '0;
  corners_t      pending_q[$];
  coarse_t       coarse_due_q[$];
  ocr_pkg::cfg_t cfg_shadow = '0;
  int            gap_left;
  bit            gaps_on = 1'b1;
  int            mismatches = 0;

  overset_coeff_restrict_top #(
    .INT_BITS  (INT_BITS),
    .FRAC_BITS (FRAC_BITS),
    .BLOCK_BITS(BLOCK_BITS)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .start       (start),
    .busy        (busy),
    .xi_base_i   (port_item.xi[0]),
    .xi_jnext_i  (port_item.xi[1]),
    .xi_knext_i  (port_item.xi[2]),
    .xi_diag_i   (port_item.xi[3]),
    .eta_base_i  (port_item.eta[0]),
    .eta_jnext_i (port_item.eta[1]),
    .eta_knext_i (port_item.eta[2]),
    .eta_diag_i  (port_item.eta[3]),
    .blk_base_i  (port_item.blk[0]),
    .blk_jnext_i (port_item.blk[1]),
    .blk_knext_i (port_item.blk[2]),
    .blk_diag_i  (port_item.blk[3]),
    .valid_o     (valid_o),
    .xi_coarse_o (xi_coarse_o),
    .eta_coarse_o(eta_coarse_o),
    .blk_coarse_o(blk_coarse_o)
  );

  always #6 clk_i = ~clk_i;

  // average of four corners, split into index and fraction, mapped to coarse
  function automatic coord_t coarse_of(input coord_t [3:0] v, input logic flat);
    logic [COORD_BITS+1:0] sum;
    coord_t                avg;
    logic [INT_BITS:0]     whole;
    logic [INT_BITS:0]     half_idx;
    logic [FRAC_BITS:0]    frac;
    logic [FRAC_BITS:0]    part;
    logic [31:0]           res;
    sum      = {2'b00, v[0]} + {2'b00, v[1]} + {2'b00, v[2]} + {2'b00, v[3]};
    avg      = sum[COORD_BITS+1:2];
    whole    = {1'b0, avg[COORD_BITS-1:FRAC_BITS]};
    frac     = {1'b0, avg[FRAC_BITS-1:0]};
    half_idx = (whole + 1'b1) >> 1;
    if (flat) begin
      part = frac;
    end else if (!whole[0]) begin
      part = (frac + {1'b1, {FRAC_BITS{1'b0}}}) >> 1;
    end else begin
      part = frac >> 1;
    end
    res = 32'(half_idx);
    res = (res << FRAC_BITS) + 32'(part);
    return res[COORD_BITS-1:0];
  endfunction

  function automatic coarse_t restrict_corners(input corners_t c, input ocr_pkg::cfg_t cfg);
    corners_t s;
    coarse_t  r;
    s = c;
    // a corner in another donor block falls back to the lower corner
    for (int i = 1; i < 4; i++) begin
      if (c.blk[i] != c.blk[0]) begin
        s.xi[i]  = c.xi[0];
        s.eta[i] = c.eta[0];
      end
    end
    r.xi  = coarse_of(s.xi, cfg.xi_two_d);
    r.eta = coarse_of(s.eta, cfg.eta_two_d);
    r.blk = c.blk[0];
    return r;
  endfunction

  function automatic corners_t same_corners(input coord_t x, input coord_t e, input blk_t b);
    corners_t c;
    for (int i = 0; i < 4; i++) begin
      c.xi[i]  = x;
      c.eta[i] = e;
      c.blk[i] = b;
    end
    return c;
  endfunction

  function automatic corners_t rand_corners();
    corners_t c;
    int       mode;
    coord_t   bx;
    coord_t   be;
    mode     = $urandom_range(0, 9);
    bx       = coord_t'($urandom);
    be       = coord_t'($urandom);
    c.blk[0] = blk_t'($urandom);
    for (int i = 0; i < 4; i++) begin
      if (i > 0) begin
        c.blk[i] = ($urandom_range(0, 3) == 0) ? blk_t'($urandom) : c.blk[0];
      end
      if (mode == 0) begin
        c.xi[i]  = $urandom_range(0, 1) ? COORD_MAX : '0;
        c.eta[i] = $urandom_range(0, 1) ? COORD_MAX : '0;
      end else if (mode < 5) begin
        // neighboring corners sit close together on a real grid
        c.xi[i]  = bx + coord_t'($urandom_range(0, 511));
        c.eta[i] = be + coord_t'($urandom_range(0, 511));
      end else begin
        c.xi[i]  = coord_t'($urandom);
        c.eta[i] = coord_t'($urandom);
      end
    end
    return c;
  endfunction

  task automatic push_directed();
    corners_t c;
    pending_q.push_back(same_corners('0, '0, '0));
    pending_q.push_back(same_corners(COORD_MAX, COORD_MAX, BLK_MAX));
    c = same_corners(COORD_MAX, '0, 10'h2AA);
    c.xi[0]  = '0;
    c.eta[0] = COORD_MAX;
    pending_q.push_back(c);
    // each neighbor alone in a foreign block, then all three
    for (int i = 1; i < 4; i++) begin
      c.blk[i] = 10'h155;
      pending_q.push_back(c);
      c.blk[i] = 10'h2AA;
    end
    c.blk[3:1] = {3{10'h155}};
    pending_q.push_back(c);
    pending_q.push_back(same_corners({10'd2, 16'h8000}, {10'd6, 16'hFFFF}, 10'd0));
    pending_q.push_back(same_corners({10'd3, 16'h4001}, {10'd1023, 16'h0001}, 10'd1));
    pending_q.push_back(same_corners({10'd0, 16'hFFFF}, {10'd1022, 16'h0000}, 10'd5));
    // fraction bits lost in the average
    c = same_corners('0, '0, 10'd7);
    c.xi[3]  = 26'd3;
    c.eta[1] = {10'd1, 16'h0003};
    pending_q.push_back(c);
  endtask

  task automatic write_reg(input ocr_pkg::reg_idx_e idx, input logic val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= ($urandom & ~32'h1) | 32'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == ocr_pkg::REG_XI_TWO_D) begin
      cfg_shadow.xi_two_d = val;
    end else begin
      cfg_shadow.eta_two_d = val;
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk_i); while (pending_q.size() != 0 || start || coarse_due_q.size() != 0);
    repeat (LATENCY + 4) @(negedge clk_i);
  endtask

  task automatic flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t mismatch: %s", $realtime, msg);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start     <= 1'b0;
      port_item <= '0;
      gap_left  = 0;
    end else begin
      if (start && !busy) begin
        coarse_due_q.push_back(restrict_corners(port_item, cfg_shadow));
      end
      if (start && busy) begin
        // transaction not taken yet, hold it
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_q.size() > 0) begin
        port_item <= pending_q.pop_front();
        start     <= 1'b1;
        if (gaps_on && $urandom_range(0, 7) == 0) begin
          gap_left = $urandom_range(1, 9);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    coarse_t got;
    coarse_t want;
    if (rst_ni && valid_o) begin
      got = '{xi_coarse_o, eta_coarse_o, blk_coarse_o};
      if (coarse_due_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected result xi %h eta %h blk %h",
                                got.xi, got.eta, got.blk));
      end else begin
        want = coarse_due_q.pop_front();
        if (got.xi !== want.xi || got.eta !== want.eta || got.blk !== want.blk) begin
          flag_mismatch($sformatf("xi exp %h got %h, eta exp %h got %h, blk exp %h got %h",
                                  want.xi, got.xi, want.eta, got.eta, want.blk, got.blk));
        end
      end
    end
  end

  initial begin
    logic xi_flat;
    logic eta_flat;
    rst_ni  = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    // both flags off, each on alone, both on, then off again without gaps
    for (int p = 0; p < 5; p++) begin
      xi_flat  = (p == 1 || p == 3);
      eta_flat = (p == 2 || p == 3);
      write_reg(ocr_pkg::REG_XI_TWO_D, xi_flat);
      write_reg(ocr_pkg::REG_ETA_TWO_D, eta_flat);
      @(negedge clk_i);
      gaps_on = (p != 4);
      if (p == 0 || p == 3) begin
        push_directed();
      end
      for (int n = 0; n < 130; n++) begin
        pending_q.push_back(rand_corners());
      end
      wait_drained();
    end
    if (mismatches == 0 && coarse_due_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
